// ===== hw/rtl/lis_pkg.sv =====
// ============================================================================
// Line index scanner package
// Shared constants, codes and types for the line index scanner.
// ============================================================================
`default_nettype none

package lis_pkg;

   // Width of the offset and line counters; counters saturate at all ones.
   localparam int OFFSET_BITS = 48;
   localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

   // Width of the sample shift register.
   localparam int SHIFT_BITS = 6;

   // The newline byte.
   localparam logic [7:0] NL_BYTE = 8'h0A;

   // Reset values of the configuration registers.
   localparam logic [1:0]            START_RESET = 2'd0;
   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(20);

   // Result queue depth and pointer widths.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Input item codes.
   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } op_type;

   // Result item codes.
   typedef enum logic {
      KIND_CHECKPOINT = 1'b0,
      KIND_TOTALS     = 1'b1
   } kind_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_OFFSET = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_SHIFT = 2'd1;

   // One result item.
   typedef struct packed {
      kind_type               kind;
      logic [OFFSET_BITS-1:0] offset;
      logic [OFFSET_BITS-1:0] line_number;
      logic [OFFSET_BITS-1:0] longest;
      logic                   last;
   } result_type;

endpackage : lis_pkg

`default_nettype wire

// ===== hw/rtl/line_index_scanner_unit.sv =====
// ============================================================================
// Line index scanner unit
// Counts newlines in a byte stream, emits periodic offset checkpoints and
// file totals (size, line count, longest terminated line).
// ============================================================================
// The unit takes one file byte per clock while the result queue has room for
// two items. Each byte is handled in the cycle it is accepted: the position,
// newline and line-length registers update at that edge and any result is
// pushed into a four-entry result queue, so the input never waits on a single
// stalled result. A data byte yields at most one checkpoint; the end marker
// yields an optional checkpoint plus the totals item, so it pushes two queue
// entries when both appear. After the end marker the counters restart for the
// next file.
`default_nettype none

module line_index_scanner_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input items.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  wire logic                            req_tuser,  // [0] op
   // Result items.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [47:0] offset, [95:48] line_number, [143:96] longest
   output      logic [3*lis_pkg::OFFSET_BITS-1:0] rsp_tdata,
   output      logic                            rsp_tuser,  // [0] kind
   output      logic                            rsp_tlast,
   // Configuration writes.
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [lis_pkg::SHIFT_BITS-1:0]  csr_data
);

   import lis_pkg::*;

   // Configuration registers.
   logic [1:0]            start_offset_ff, start_offset_in;
   logic [SHIFT_BITS-1:0] sample_shift_ff, sample_shift_in;

   // Scan state.
   logic [OFFSET_BITS-1:0] position_ff, position_in;
   logic [OFFSET_BITS-1:0] newline_count_ff, newline_count_in;
   logic [OFFSET_BITS-1:0] line_begin_ff, line_begin_in;
   logic [OFFSET_BITS-1:0] longest_seen_ff, longest_seen_in;

   // Result queue.
   result_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                   item_accept;
   logic                   csr_accept;
   logic                   pop;
   logic [1:0]             push_count;
   result_type             res_a;
   result_type             res_b;
   result_type             head;
   logic                   is_checkpoint;
   logic [OFFSET_BITS-1:0] spacing_mask;
   logic [OFFSET_BITS-1:0] start_ext;
   logic [OFFSET_BITS-1:0] position_inc;
   logic [OFFSET_BITS-1:0] line_len;
   logic [OFFSET_BITS-1:0] total_lines;
   logic                   is_newline;
   op_type                 op;

   // Handshakes: room for two results lets any item in.
   assign csr_ready   = 1'b1;
   assign csr_accept  = csr_valid && csr_ready;
   assign req_tready  = (count_ff <= CNT_BITS'(QUEUE_DEPTH - 2));
   assign item_accept = req_tvalid && req_tready;
   assign rsp_tvalid  = (count_ff != '0);
   assign pop         = rsp_tvalid && rsp_tready;

   assign op         = op_type'(req_tuser);
   assign is_newline = (req_tdata == NL_BYTE);
   assign start_ext  = OFFSET_BITS'(start_offset_ff);

   // Checkpoint test on the current position.
   always_comb begin
      spacing_mask  = ~(CNT_MAX << sample_shift_ff);
      is_checkpoint = (32'(sample_shift_ff) < OFFSET_BITS) &&
                      (position_ff != CNT_MAX) &&
                      (position_ff > start_ext) &&
                      ((position_ff & spacing_mask) == '0);
   end

   // Saturating increments and line length.
   always_comb begin
      position_inc = (position_ff == CNT_MAX) ? CNT_MAX : position_ff + 1'b1;
      line_len     = (position_ff < line_begin_ff) ? '0 : position_ff - line_begin_ff;
      total_lines  = newline_count_ff;
      if (position_ff > line_begin_ff && newline_count_ff != CNT_MAX) begin
         total_lines = newline_count_ff + 1'b1;
      end
   end

   // Result items and scan state update for the accepted item.
   always_comb begin
      result_type cp;
      result_type tot;

      cp.kind         = KIND_CHECKPOINT;
      cp.offset       = position_ff;
      cp.line_number  = newline_count_ff;
      cp.longest      = '0;
      cp.last         = (op == OP_DATA);

      tot.kind        = KIND_TOTALS;
      tot.offset      = position_ff;
      tot.line_number = total_lines;
      tot.longest     = longest_seen_ff;
      tot.last        = 1'b1;

      res_a            = cp;
      res_b            = tot;
      push_count       = 2'd0;
      position_in      = position_ff;
      newline_count_in = newline_count_ff;
      line_begin_in    = line_begin_ff;
      longest_seen_in  = longest_seen_ff;

      if (item_accept) begin
         case (op)
            OP_DATA: begin
               push_count  = is_checkpoint ? 2'd1 : 2'd0;
               position_in = position_inc;
               if (is_newline) begin
                  if (line_len > longest_seen_ff) begin
                     longest_seen_in = line_len;
                  end
                  newline_count_in = (newline_count_ff == CNT_MAX) ?
                                     CNT_MAX : newline_count_ff + 1'b1;
                  line_begin_in    = position_inc;
               end
            end
            OP_END: begin
               if (is_checkpoint) begin
                  push_count = 2'd2;
               end else begin
                  res_a      = tot;
                  push_count = 2'd1;
               end
               // Restart for the next file.
               position_in      = start_ext;
               newline_count_in = '0;
               line_begin_in    = start_ext;
               longest_seen_in  = '0;
            end
            default: begin
               push_count = 2'd0;
            end
         endcase
      end
   end

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      start_offset_in = start_offset_ff;
      sample_shift_in = sample_shift_ff;
      if (csr_accept) begin
         case (csr_index)
            CSR_START_OFFSET: start_offset_in = csr_data[1:0];
            CSR_SAMPLE_SHIFT: sample_shift_in = csr_data;
            default: begin
               start_offset_in = start_offset_ff;
            end
         endcase
      end
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_offset_ff  <= START_RESET;
         sample_shift_ff  <= SHIFT_RESET;
         position_ff      <= OFFSET_BITS'(START_RESET);
         newline_count_ff <= '0;
         line_begin_ff    <= OFFSET_BITS'(START_RESET);
         longest_seen_ff  <= '0;
         rd_ptr_ff        <= '0;
         wr_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         start_offset_ff  <= start_offset_in;
         sample_shift_ff  <= sample_shift_in;
         position_ff      <= position_in;
         newline_count_ff <= newline_count_in;
         line_begin_ff    <= line_begin_in;
         longest_seen_ff  <= longest_seen_in;
         rd_ptr_ff        <= rd_ptr_in;
         wr_ptr_ff        <= wr_ptr_in;
         count_ff         <= count_in;
      end
   end

   // Queue storage: up to two entries written per accepted item.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res_a;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res_b;
      end
   end

   // Result port from the queue head.
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {head.longest, head.line_number, head.offset};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule : line_index_scanner_unit

`default_nettype wire

// ===== tb/line_index_scanner_unit_tb.sv =====
// ============================================================================
// Line index scanner unit testbench
// Streams files byte by byte into the scanner and checks every checkpoint
// and totals item against a cycle-free predictor kept in the testbench.
// Directed files cover empty files, leading and doubled newlines, trailing
// partial lines, a three-byte start offset, wide checkpoint spacing and
// writes to unused register indexes. Random files follow under changing
// settings and idle patterns, with one long receiver stall and a drain
// between settings.
// ============================================================================
module line_index_scanner_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lis_pkg::*;

   // Register indexes the block does not implement; writes must be ignored.
   localparam logic [1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [1:0] CSR_SPARE_HIGH = 2'd3;

   // Length of the long receiver stall, in cycles.
   localparam int STALL_CYCLES = 300;

   // One input item waiting to be driven.
   typedef struct {
      op_type     op;
      logic [7:0] data;
   } stream_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = 8'd0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [3*OFFSET_BITS-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [1:0]              csr_index  = 2'd0;
   logic [SHIFT_BITS-1:0]   csr_data   = '0;

   // Items still to be driven, and index records still to be received.
   stream_item_type file_stream[$];
   result_type      records_due[$];

   // Predictor state: configuration and per-file counters.
   logic [1:0]             cfg_start;
   logic [SHIFT_BITS-1:0]  cfg_shift;
   logic [OFFSET_BITS-1:0] position;
   logic [OFFSET_BITS-1:0] newlines;
   logic [OFFSET_BITS-1:0] line_begin;
   logic [OFFSET_BITS-1:0] longest_line;

   // Idle pattern and stall control.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        stall_start   = 1'b0;
   int unsigned stall_left;

   // Run statistics.
   int unsigned error_count      = 0;
   int unsigned items_accepted   = 0;
   int unsigned checkpoints_seen = 0;
   int unsigned totals_seen      = 0;
   int unsigned csr_writes       = 0;
   int unsigned items_queued     = 0;

   line_index_scanner_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // A checkpoint falls on offsets above the start that are multiples of the
   // spacing, never at the saturated top and never with too wide a spacing.
   function automatic logic checkpoint_due(input logic [OFFSET_BITS-1:0] off);
      logic [OFFSET_BITS-1:0] spacing_mask;
      if (cfg_shift >= OFFSET_BITS) return 1'b0;
      if (off == CNT_MAX || off <= OFFSET_BITS'(cfg_start)) return 1'b0;
      spacing_mask = (OFFSET_BITS'(1) << cfg_shift) - 1'b1;
      return (off & spacing_mask) == '0;
   endfunction

   function automatic result_type make_record(input kind_type kind,
                                              input logic [OFFSET_BITS-1:0] off,
                                              input logic [OFFSET_BITS-1:0] lines,
                                              input logic [OFFSET_BITS-1:0] lng,
                                              input logic last);
      result_type rec;
      rec.kind        = kind;
      rec.offset      = off;
      rec.line_number = lines;
      rec.longest     = lng;
      rec.last        = last;
      return rec;
   endfunction

   // Counters go back to the start of a file; only here does the start
   // offset move the position.
   task automatic restart_file();
      position     = OFFSET_BITS'(cfg_start);
      newlines     = '0;
      line_begin   = OFFSET_BITS'(cfg_start);
      longest_line = '0;
   endtask

   // Work out the records one accepted item causes.
   task automatic scan_item(input op_type op, input logic [7:0] data);
      logic [OFFSET_BITS-1:0] lines;
      if (op == OP_DATA) begin
         if (checkpoint_due(position))
            records_due.insert(records_due.size(),
               make_record(KIND_CHECKPOINT, position, newlines, '0, 1'b1));
         if (data == NL_BYTE) begin
            if (position >= line_begin && position - line_begin > longest_line)
               longest_line = position - line_begin;
            newlines   = sat_inc(newlines);
            position   = sat_inc(position);
            line_begin = position;
         end else begin
            position = sat_inc(position);
         end
      end else begin
         if (checkpoint_due(position))
            records_due.insert(records_due.size(),
               make_record(KIND_CHECKPOINT, position, newlines, '0, 1'b0));
         // A trailing line without a newline still counts as a line.
         lines = newlines;
         if (position > line_begin) lines = sat_inc(lines);
         records_due.insert(records_due.size(),
            make_record(KIND_TOTALS, position, lines, longest_line, 1'b1));
         restart_file();
      end
   endtask

   // ------------------------------------------------------------------------
   // Input driver
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : drive_items
      stream_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_item(op_type'(req_tuser), req_tdata);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (file_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = file_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.data;
               req_tuser  <= next_item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [OFFSET_BITS-1:0] want,
                                input logic [OFFSET_BITS-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_records
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = make_record(kind_type'(rsp_tuser), rsp_tdata[OFFSET_BITS-1:0],
                               rsp_tdata[2*OFFSET_BITS-1:OFFSET_BITS],
                               rsp_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS], rsp_tlast);
            if (seen.kind == KIND_TOTALS) totals_seen++;
            else checkpoints_seen++;
            if (records_due.size() == 0) begin
               $error("unexpected result item: kind %0d offset %0d", seen.kind, seen.offset);
               error_count++;
            end else begin
               want = records_due.pop_front();
               compare_field("kind", OFFSET_BITS'(want.kind), OFFSET_BITS'(seen.kind));
               compare_field("offset", want.offset, seen.offset);
               compare_field("line_number", want.line_number, seen.line_number);
               compare_field("longest", want.longest, seen.longest);
               compare_field("last", OFFSET_BITS'(want.last), OFFSET_BITS'(seen.last));
            end
         end
         rsp_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Long receiver stall, counted down on its own.
   always @(posedge clock) begin
      if (reset)
         stall_left <= 0;
      else if (stall_start)
         stall_left <= STALL_CYCLES;
      else if (stall_left != 0)
         stall_left <= stall_left - 1;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   task automatic push_item(input op_type op, input logic [7:0] data);
      stream_item_type item;
      item.op   = op;
      item.data = data;
      file_stream.insert(file_stream.size(), item);
      items_queued++;
   endtask

   // Wait until every item is taken and every record has come back, then let
   // the block settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (file_stream.size() != 0 || req_tvalid || records_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [SHIFT_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_START_OFFSET) cfg_start = value[1:0];
      else if (idx == CSR_SAMPLE_SHIFT) cfg_shift = value;
      csr_writes++;
   endtask

   // One random file: mostly short lines, now and then a long one, then
   // the end marker.
   task automatic queue_file();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(0, 16);
      repeat (len) begin
         if ($urandom_range(0, 4) == 0) push_item(OP_DATA, NL_BYTE);
         else push_item(OP_DATA, 8'($urandom_range(0, 255)));
      end
      push_item(OP_END, 8'($urandom));
   endtask

   // New settings, an empty file so the start offset takes hold, then random
   // files. Checkpoint spacing is mostly tight so that checkpoints are common.
   task automatic run_segment(input int unsigned count, input logic with_stall);
      int unsigned pick;
      int unsigned target;
      logic [SHIFT_BITS-1:0] shift;
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick < 7)       shift = SHIFT_BITS'($urandom_range(0, 4));
      else if (pick == 7) shift = SHIFT_BITS'($urandom_range(5, 47));
      else if (pick == 8) shift = SHIFT_BITS'(47);
      else                shift = SHIFT_BITS'($urandom_range(48, 63));
      write_csr(CSR_SAMPLE_SHIFT, shift);
      write_csr(CSR_START_OFFSET, SHIFT_BITS'($urandom_range(0, 3)));
      target = items_queued + count;
      push_item(OP_END, 8'd0);
      while (items_queued < target) queue_file();
      if (with_stall) begin
         @(posedge clock);
         stall_start <= 1'b1;
         @(posedge clock);
         stall_start <= 1'b0;
      end
   endtask

   initial begin
      cfg_start = START_RESET;
      cfg_shift = SHIFT_RESET;
      restart_file();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed files, sender rarely idle and receiver mostly idle.
      send_idle_pct = 13;
      recv_idle_pct = 88;
      write_csr(CSR_SAMPLE_SHIFT, SHIFT_BITS'(0));
      write_csr(CSR_SPARE_LOW, SHIFT_BITS'(63));
      write_csr(CSR_SPARE_HIGH, SHIFT_BITS'(42));
      // Empty file, then a file that opens with two newlines, covers the
      // byte extremes and ends in a partial line.
      push_item(OP_END, 8'hFF);
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_DATA, 8'h00);
      push_item(OP_DATA, 8'hFF);
      push_item(OP_DATA, 8'h55);
      push_item(OP_DATA, 8'hAA);
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_DATA, 8'h0B);
      push_item(OP_DATA, 8'h09);
      push_item(OP_END, 8'h00);
      wait_idle();
      // Start offset of three: the empty file moves the position there.
      write_csr(CSR_START_OFFSET, SHIFT_BITS'(3));
      write_csr(CSR_SAMPLE_SHIFT, SHIFT_BITS'(1));
      push_item(OP_END, 8'h00);
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_DATA, 8'h61);
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_END, 8'h00);
      wait_idle();
      // Widest legal spacing and spacing beyond the counter width.
      write_csr(CSR_SAMPLE_SHIFT, SHIFT_BITS'(47));
      push_item(OP_DATA, NL_BYTE);
      push_item(OP_DATA, 8'h41);
      push_item(OP_END, 8'h00);
      wait_idle();
      write_csr(CSR_SAMPLE_SHIFT, SHIFT_BITS'(63));
      push_item(OP_DATA, 8'h7E);
      push_item(OP_END, 8'h00);

      // Random files under three idle patterns.
      run_segment(62, 1'b0);
      run_segment(62, 1'b0);
      wait_idle();
      send_idle_pct = 88;
      recv_idle_pct = 13;
      run_segment(62, 1'b0);
      run_segment(62, 1'b0);
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(62, 1'b1);
      run_segment(62, 1'b0);

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Scanned %0d items with %0d register writes across several spacings and offsets.",
               items_accepted, csr_writes);
      $display("Checked %0d checkpoints and %0d file totals under varied idling and one long stall.",
               checkpoints_seen, totals_seen);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog.
   initial begin
      #4_000_000;
      $error("run did not finish in time");
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/lis_pkg.sv
hw/rtl/line_index_scanner_unit.sv
tb/line_index_scanner_unit_tb.sv
